[sv/bosi_pkg.sv]
// ----------------------------------------------------------------------------
// Bind opcode stream interpreter: shared types and constants
// Holds the item types of both queue ports, the command passed from the
// byte parser to the record executor, and the register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bosi_pkg;

  // Configuration register indexes and width of the write port.
  localparam int unsigned CFG_DATA_W  = 4;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_POINTER_SIZE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STOP_AT_DONE = 1'd1;

  // Reset values of the configuration registers.
  localparam logic [CFG_DATA_W-1:0] POINTER_SIZE_RESET = 4'd8;
  localparam logic                  STOP_AT_DONE_RESET = 1'b1;

  // Default depths of the command queue and the result queue.
  localparam int unsigned CMD_FIFO_DEPTH = 2;
  localparam int unsigned RES_FIFO_DEPTH = 2;

  // Kind of a result item.
  typedef enum logic [1:0] {
    KIND_BIND      = 2'd0,
    KIND_FINISHED  = 2'd1,
    KIND_UNKNOWN   = 2'd2,
    KIND_TRUNCATED = 2'd3
  } kind_e;

  // Record operation carried by one command.
  typedef enum logic [3:0] {
    ACT_NONE    = 4'd0,
    ACT_CLEAR   = 4'd1,
    ACT_ORD     = 4'd2,
    ACT_FLAGS   = 4'd3,
    ACT_TYPE    = 4'd4,
    ACT_SEG     = 4'd5,
    ACT_ADDEND  = 4'd6,
    ACT_SET_OFF = 4'd7,
    ACT_ADD_OFF = 4'd8,
    ACT_BIND    = 4'd9,
    ACT_REPEAT  = 4'd10
  } act_e;

  // One stream byte with its framing marks.
  typedef struct packed {
    logic [7:0] stream_byte;
    logic       first_byte;
    logic       last_byte;
  } in_item_t;

  // One result item.
  typedef struct packed {
    kind_e              result_kind;
    logic        [31:0] record_start;
    logic        [3:0]  segment_index;
    logic        [63:0] segment_offset;
    logic        [3:0]  bind_type;
    logic        [3:0]  symbol_flags;
    logic signed [31:0] library_ordinal;
    logic        [31:0] symbol_position;
    logic signed [63:0] addend;
    logic        [63:0] repeat_count;
    logic        [63:0] run_stride;
  } out_item_t;

  // Command from the parser to the executor. The record is cleared first
  // when first is set, then the operation is applied, then a status result
  // follows when emit_status is set.
  typedef struct packed {
    logic        first;
    act_e        act;
    logic        emit_status;
    kind_e       kind;
    logic [3:0]  imm;
    logic [31:0] pos;
    logic [63:0] val_a;
    logic [63:0] val_b;
  } cmd_t;

endpackage

[sv/bosi_fifo.sv]
// ----------------------------------------------------------------------------
// Small synchronous queue
// Register-based first-in first-out queue with a type parameter; used for
// the command queue and the result queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bosi_fifo #(
  parameter type         T     = logic,
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  T                entries_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = entries_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[sv/bosi_front.sv]
// ----------------------------------------------------------------------------
// Bind stream parser
// Takes one stream byte per cycle while the command queue has room, splits opcodes,
// assembles LEB operands, skips symbol strings and issues record commands to the executor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bosi_front
  import bosi_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   in_valid_i,
  input  in_item_t               in_data_i,
  output logic                   in_ready_o,
  output logic                   cmd_push_o,
  output cmd_t                   cmd_o,
  input  logic                   cmd_full_i
);

  // Parser phases.
  localparam logic [2:0] PH_OPCODE = 3'd0;
  localparam logic [2:0] PH_ULEB   = 3'd1;
  localparam logic [2:0] PH_ULEB2  = 3'd2;
  localparam logic [2:0] PH_SLEB   = 3'd3;
  localparam logic [2:0] PH_SYMBOL = 3'd4;

  // Opcodes (high nibble of an opcode byte).
  localparam logic [3:0] OP_DONE         = 4'h0;
  localparam logic [3:0] OP_ORD_IMM      = 4'h1;
  localparam logic [3:0] OP_ORD_ULEB     = 4'h2;
  localparam logic [3:0] OP_ORD_SPECIAL  = 4'h3;
  localparam logic [3:0] OP_SYMBOL       = 4'h4;
  localparam logic [3:0] OP_TYPE         = 4'h5;
  localparam logic [3:0] OP_ADDEND       = 4'h6;
  localparam logic [3:0] OP_SEG_OFF      = 4'h7;
  localparam logic [3:0] OP_ADD_OFF      = 4'h8;
  localparam logic [3:0] OP_BIND         = 4'h9;
  localparam logic [3:0] OP_BIND_ADD     = 4'hA;
  localparam logic [3:0] OP_BIND_SCALED  = 4'hB;
  localparam logic [3:0] OP_BIND_REPEAT  = 4'hC;

  localparam logic [6:0] SHIFT_MAX = 7'd70;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] ptr_size_q;
  logic                  stop_q;

  // Parser state.
  logic [31:0] byte_pos_q, byte_pos_d;
  logic [2:0]  phase_q, phase_d;
  logic [3:0]  pend_op_q, pend_op_d;
  logic [63:0] leb_acc_q, leb_acc_d;
  logic [6:0]  leb_shift_q, leb_shift_d;
  logic [63:0] first_op_q, first_op_d;
  logic        halted_q, halted_d;

  logic        accept, active, first, last;
  logic [7:0]  b;
  logic [3:0]  op, imm;
  logic [31:0] pos, pos_next;
  logic [2:0]  phase_cur;
  logic [63:0] ptr64, acc_new, leb_val_ptr, sleb_val, scaled_step;
  logic [7:0]  shift_sum;
  logic [6:0]  shift_new;
  logic [4:0]  imm_plus;
  logic        leb_done;
  cmd_t        cmd;

  assign in_ready_o = !cmd_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign b          = in_data_i.stream_byte;
  assign first      = in_data_i.first_byte;
  assign last       = in_data_i.last_byte;
  assign active     = first || !halted_q;
  assign op         = b[7:4];
  assign imm        = b[3:0];
  assign pos        = first ? 32'd0 : byte_pos_q;
  assign pos_next   = pos + 32'd1;
  assign phase_cur  = first ? PH_OPCODE : phase_q;

  // Pointer width and the small step of a scaled bind.
  assign ptr64       = (ptr_size_q == 4'd4) ? 64'd4 : 64'd8;
  assign imm_plus    = {1'b0, imm} + 5'd1;
  assign scaled_step = (ptr_size_q == 4'd4) ? {57'd0, imm_plus, 2'b00}
                                            : {56'd0, imm_plus, 3'b000};

  // LEB byte assembly: bits past bit 63 are dropped, the shift saturates.
  assign shift_sum   = {1'b0, leb_shift_q} + 8'd7;
  assign shift_new   = (shift_sum > {1'b0, SHIFT_MAX}) ? SHIFT_MAX : shift_sum[6:0];
  assign acc_new     = (leb_shift_q < 7'd64)
                     ? (leb_acc_q | ({57'd0, b[6:0]} << leb_shift_q[5:0])) : leb_acc_q;
  assign leb_done    = !b[7];
  assign leb_val_ptr = acc_new + ptr64;
  assign sleb_val    = (shift_new < 7'd64 && b[6])
                     ? (acc_new | (~64'd0 << shift_new[5:0])) : acc_new;

  // Byte decode and command build.
  always_comb begin
    byte_pos_d  = byte_pos_q;
    phase_d     = phase_cur;
    pend_op_d   = pend_op_q;
    leb_acc_d   = leb_acc_q;
    leb_shift_d = leb_shift_q;
    first_op_d  = first_op_q;
    halted_d    = first ? 1'b0 : halted_q;

    cmd             = '0;
    cmd.first       = first;
    cmd.act         = ACT_NONE;
    cmd.kind        = KIND_BIND;
    cmd.imm         = imm;
    cmd.pos         = pos_next;

    if (active) begin
      byte_pos_d = pos_next;
      case (phase_cur)
        PH_OPCODE: begin
          pend_op_d = op;
          case (op)
            OP_DONE: begin
              if (stop_q) begin
                cmd.emit_status = 1'b1;
                cmd.kind        = KIND_FINISHED;
                halted_d        = 1'b1;
              end else begin
                cmd.act = ACT_CLEAR;
              end
            end
            OP_ORD_IMM: begin
              cmd.act   = ACT_ORD;
              cmd.val_a = {60'd0, imm};
            end
            OP_ORD_ULEB: begin
              leb_acc_d = '0; leb_shift_d = '0; phase_d = PH_ULEB;
            end
            OP_ORD_SPECIAL: begin
              cmd.act   = ACT_ORD;
              cmd.val_a = (imm == 4'd0) ? 64'd0 : {32'd0, 28'hFFFFFFF, imm};
            end
            OP_SYMBOL: begin
              cmd.act = ACT_FLAGS;
              phase_d = PH_SYMBOL;
            end
            OP_TYPE: begin
              cmd.act = ACT_TYPE;
            end
            OP_ADDEND: begin
              leb_acc_d = '0; leb_shift_d = '0; phase_d = PH_SLEB;
            end
            OP_SEG_OFF: begin
              cmd.act   = ACT_SEG;
              leb_acc_d = '0; leb_shift_d = '0; phase_d = PH_ULEB;
            end
            OP_ADD_OFF, OP_BIND_REPEAT: begin
              leb_acc_d = '0; leb_shift_d = '0; phase_d = PH_ULEB;
            end
            OP_BIND: begin
              cmd.act   = ACT_BIND;
              cmd.val_a = ptr64;
            end
            OP_BIND_ADD: begin
              // The run goes out now; the operand is added once it is complete.
              cmd.act   = ACT_BIND;
              leb_acc_d = '0; leb_shift_d = '0; phase_d = PH_ULEB;
            end
            OP_BIND_SCALED: begin
              cmd.act   = ACT_BIND;
              cmd.val_a = scaled_step;
            end
            default: begin
              cmd.emit_status = 1'b1;
              cmd.kind        = KIND_UNKNOWN;
              halted_d        = 1'b1;
            end
          endcase
        end
        PH_SYMBOL: begin
          if (b == 8'd0) begin
            phase_d = PH_OPCODE;
          end
        end
        PH_SLEB: begin
          leb_acc_d   = acc_new;
          leb_shift_d = shift_new;
          if (leb_done) begin
            cmd.act   = ACT_ADDEND;
            cmd.val_a = sleb_val;
            phase_d   = PH_OPCODE;
          end
        end
        PH_ULEB: begin
          leb_acc_d   = acc_new;
          leb_shift_d = shift_new;
          if (leb_done) begin
            phase_d = PH_OPCODE;
            case (pend_op_q)
              OP_ORD_ULEB: begin
                cmd.act   = ACT_ORD;
                cmd.val_a = acc_new;
              end
              OP_SEG_OFF: begin
                cmd.act   = ACT_SET_OFF;
                cmd.val_a = acc_new;
              end
              OP_ADD_OFF: begin
                cmd.act   = ACT_ADD_OFF;
                cmd.val_a = acc_new;
              end
              OP_BIND_ADD: begin
                cmd.act   = ACT_ADD_OFF;
                cmd.val_a = leb_val_ptr;
              end
              OP_BIND_REPEAT: begin
                first_op_d  = acc_new;
                leb_acc_d   = '0;
                leb_shift_d = '0;
                phase_d     = PH_ULEB2;
              end
              default: ;
            endcase
          end
        end
        PH_ULEB2: begin
          leb_acc_d   = acc_new;
          leb_shift_d = shift_new;
          if (leb_done) begin
            phase_d = PH_OPCODE;
            // A zero count gives no run and leaves the offset alone.
            if (first_op_q != 64'd0) begin
              cmd.act   = ACT_REPEAT;
              cmd.val_a = first_op_q;
              cmd.val_b = leb_val_ptr;
            end
          end
        end
        default: begin
          phase_d = PH_OPCODE;
        end
      endcase

      // Last byte: halt, and flag an operand or symbol name left open by this byte.
      if (last && !cmd.emit_status) begin
        halted_d = 1'b1;
        if (phase_d != PH_OPCODE) begin
          cmd.emit_status = 1'b1;
          cmd.kind        = KIND_TRUNCATED;
          if (cmd.act == ACT_BIND) begin
            cmd.act = ACT_NONE;
          end
        end
      end
    end
  end

  assign cmd_o      = cmd;
  assign cmd_push_o = accept && active
                   && (first || cmd.act != ACT_NONE || cmd.emit_status);

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_size_q <= POINTER_SIZE_RESET;
      stop_q     <= STOP_AT_DONE_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_POINTER_SIZE) begin
        ptr_size_q <= cfg_data_i;
      end else if (cfg_index_i == REG_STOP_AT_DONE) begin
        stop_q <= cfg_data_i[0];
      end
    end
  end

  // Parser state registers, advanced on every accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q  <= '0;
      phase_q     <= PH_OPCODE;
      pend_op_q   <= '0;
      leb_acc_q   <= '0;
      leb_shift_q <= '0;
      first_op_q  <= '0;
      halted_q    <= 1'b0;
    end else if (accept) begin
      byte_pos_q  <= byte_pos_d;
      phase_q     <= phase_d;
      pend_op_q   <= pend_op_d;
      leb_acc_q   <= leb_acc_d;
      leb_shift_q <= leb_shift_d;
      first_op_q  <= first_op_d;
      halted_q    <= halted_d;
    end
  end

  // A halted parser ignores bytes that do not open a new stream.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && halted_q && !in_data_i.first_byte) |-> !cmd_push_o)
    else $error("command issued while halted");

  // Commands are only issued into a queue with room.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push_o |-> !cmd_full_i)
    else $error("command pushed into a full queue");

  // The last byte of a stream always halts the parser.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.last_byte) |=> halted_q)
    else $error("parser not halted after last byte");

endmodule

[sv/bosi_back.sv]
// ----------------------------------------------------------------------------
// Bind record executor
// Holds the current bind record, applies parser commands to it and builds
// result items; a repeat run multiplies count by stride in a sequence of steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bosi_back
  import bosi_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_empty_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  output logic      res_push_o,
  output out_item_t res_o,
  input  logic      res_full_i
);

  // Steps of the count times stride product; LL, LH and HL each form one 32x32 product.
  localparam logic [2:0] STEP_IDLE = 3'd0;
  localparam logic [2:0] STEP_LL   = 3'd1;
  localparam logic [2:0] STEP_LH   = 3'd2;
  localparam logic [2:0] STEP_HL   = 3'd3;
  localparam logic [2:0] STEP_SUM  = 3'd4;
  localparam logic [2:0] STEP_ADD  = 3'd5;

  typedef struct packed {
    logic [31:0] start;
    logic [3:0]  segment;
    logic [63:0] offset;
    logic [3:0]  btype;
    logic [3:0]  flags;
    logic [31:0] ordinal;
    logic [31:0] sym_pos;
    logic [63:0] addend;
  } rec_t;

  rec_t        rec_q, rec_d, rec_c, rec_e;
  logic [2:0]  step_q, step_d;
  logic [63:0] count_q, stride_q;
  logic [63:0] prod_q, prod_d, sum_q, sum_d;
  logic [31:0] mul_a, mul_b;
  logic [63:0] off_sum;
  logic        need_emit, is_bind, is_repeat;

  assign is_bind   = (cmd_i.act == ACT_BIND);
  assign is_repeat = (cmd_i.act == ACT_REPEAT);
  assign need_emit = is_bind || is_repeat || cmd_i.emit_status;
  assign cmd_pop_o = !cmd_empty_i && (step_q == STEP_IDLE) && !(need_emit && res_full_i);
  assign res_push_o = cmd_pop_o && need_emit;

  // Record as seen by the command: cleared on a new stream, then updated.
  always_comb begin
    rec_c = rec_q;
    if (cmd_i.first) begin
      rec_c = '0;
    end
    off_sum = rec_c.offset + cmd_i.val_a;
    rec_e   = rec_c;
    case (cmd_i.act)
      ACT_CLEAR: begin
        rec_e       = '0;
        rec_e.start = cmd_i.pos;
      end
      ACT_ORD:     rec_e.ordinal = cmd_i.val_a[31:0];
      ACT_FLAGS: begin
        rec_e.flags   = cmd_i.imm;
        rec_e.sym_pos = cmd_i.pos;
      end
      ACT_TYPE:    rec_e.btype   = cmd_i.imm;
      ACT_SEG:     rec_e.segment = cmd_i.imm;
      ACT_ADDEND:  rec_e.addend  = cmd_i.val_a;
      ACT_SET_OFF: rec_e.offset  = cmd_i.val_a;
      ACT_ADD_OFF: rec_e.offset  = off_sum;
      default: ;
    endcase
  end

  // Result item built from the record before any run advance.
  always_comb begin
    res_o                 = '0;
    res_o.result_kind     = cmd_i.emit_status ? cmd_i.kind : KIND_BIND;
    res_o.record_start    = rec_e.start;
    res_o.segment_index   = rec_e.segment;
    res_o.segment_offset  = rec_e.offset;
    res_o.bind_type       = rec_e.btype;
    res_o.symbol_flags    = rec_e.flags;
    res_o.library_ordinal = $signed(rec_e.ordinal);
    res_o.symbol_position = rec_e.sym_pos;
    res_o.addend          = $signed(rec_e.addend);
    if (is_bind) begin
      res_o.repeat_count = 64'd1;
    end else if (is_repeat) begin
      res_o.repeat_count = cmd_i.val_a;
      res_o.run_stride   = cmd_i.val_b;
    end
  end

  // Shared multiplier: low 64 bits of count times stride from three products.
  assign mul_a  = (step_q == STEP_HL) ? count_q[63:32] : count_q[31:0];
  assign mul_b  = (step_q == STEP_LH) ? stride_q[63:32] : stride_q[31:0];

  always_comb begin
    rec_d  = rec_q;
    step_d = step_q;
    prod_d = prod_q;
    sum_d  = sum_q;
    case (step_q)
      STEP_IDLE: begin
        if (cmd_pop_o) begin
          rec_d = rec_e;
          if (is_bind) begin
            rec_d.offset = off_sum;
          end
          if (is_repeat) begin
            step_d = STEP_LL;
          end
        end
      end
      STEP_LL: begin
        prod_d = {32'd0, mul_a} * {32'd0, mul_b};
        step_d = STEP_LH;
      end
      STEP_LH: begin
        sum_d  = prod_q;
        prod_d = {32'd0, mul_a} * {32'd0, mul_b};
        step_d = STEP_HL;
      end
      STEP_HL: begin
        sum_d  = sum_q + {prod_q[31:0], 32'd0};
        prod_d = {32'd0, mul_a} * {32'd0, mul_b};
        step_d = STEP_SUM;
      end
      STEP_SUM: begin
        sum_d  = sum_q + {prod_q[31:0], 32'd0};
        step_d = STEP_ADD;
      end
      STEP_ADD: begin
        rec_d.offset = rec_q.offset + sum_q;
        step_d       = STEP_IDLE;
      end
      default: begin
        step_d = STEP_IDLE;
      end
    endcase
  end

  // Record and sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q  <= '0;
      step_q <= STEP_IDLE;
    end else begin
      rec_q  <= rec_d;
      step_q <= step_d;
    end
  end

  // Run operands and product pipeline registers.
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o && is_repeat) begin
      count_q  <= cmd_i.val_a;
      stride_q <= cmd_i.val_b;
    end
    prod_q <= prod_d;
    sum_q  <= sum_d;
  end

  // No command is taken while a run product is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q != STEP_IDLE) |-> !cmd_pop_o)
    else $error("command taken during run product");

  // Results only go into a result queue with room.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into a full queue");

  // A run product ends with the offset update and returns to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == STEP_ADD) |=> (step_q == STEP_IDLE))
    else $error("run product sequence broken");

endmodule

[sv/bind_opcode_stream_interpreter_top.sv]
// ----------------------------------------------------------------------------
// Bind opcode stream interpreter
// Input bytes enter through a push/full queue port; each byte is parsed and
// turned into commands, and bind runs and status items leave through an
// empty/pop queue port.
//
// Usage:
//   One stream byte is transferred per cycle when push is high and full is
//   low. first_byte opens a new stream, last_byte closes it. Results are read
//   with pop while empty is low; at most one result follows from a byte.
//   Configuration (pointer size, stop at DONE) is written through cfg_we_i,
//   cfg_index_i and cfg_data_i while the block is idle.
// Result path and throughput:
//   A result passes through the command queue and then the result queue
//   before it is on the output ports. Bytes are taken at one per cycle
//   while full is low. A repeat run occupies the record executor while the
//   shared 32x32 multiplier forms count times stride; the command queue
//   fills behind it and full rises when it is out of room.
// Reset and stalls:
//   Reset clears the record, the parser, both queues and loads the register
//   defaults. When the receiver holds off pop, results wait in the result
//   queue, the executor then stops and full rises once the command queue fills.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bind_opcode_stream_interpreter_top
  import bosi_pkg::*;
#(
  parameter int unsigned CmdDepth = CMD_FIFO_DEPTH,
  parameter int unsigned ResDepth = RES_FIFO_DEPTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   push,
  input  in_item_t               in_data_i,
  output logic                   full,
  input  logic                   pop,
  output out_item_t              out_data_o,
  output logic                   empty
);

  logic      in_ready;
  logic      cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t      cmd_in, cmd_out;
  logic      res_push, res_full;
  out_item_t res_in;

  assign full = !in_ready;

  // Byte parser.
  bosi_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (push),
    .in_data_i   (in_data_i),
    .in_ready_o  (in_ready),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in),
    .cmd_full_i  (cmd_full)
  );

  // Command queue between parser and executor.
  bosi_fifo #(
    .T     (cmd_t),
    .DEPTH (CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  // Record executor.
  bosi_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .res_full_i  (res_full)
  );

  // Result queue facing the receiver.
  bosi_fifo #(
    .T     (out_item_t),
    .DEPTH (ResDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_data_o),
    .empty_o (empty)
  );

endmodule
